// ----- design/adit_pkg.sv -----
// Package for the aged device id table: command and status codes,
// the slot entry and result types, and the slot read-out function.
// No dependencies; adit_cfg_if and the top level use it by scoped names.
package adit_pkg;

	// Width of the configuration register index.
	localparam int CfgIdxW = 1;

	// Limit value at reset, and the data age of a slot that was never written.
	localparam logic [3:0] LimitAtReset = 4'd10;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_SEEN_LIMIT = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_DATA_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		CMD_SEEN  = 3'd0,
		CMD_STORE = 3'd1,
		CMD_END   = 3'd2,
		CMD_RSLOT = 3'd3,
		CMD_RID   = 3'd4
	} cmd_e_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_EMPTY    = 2'd1,
		STS_STALE    = 2'd2,
		STS_NOTFOUND = 2'd3
	} status_t;

	// One slot of the table.
	typedef struct packed {
		logic [63:0]        id;
		logic [3:0]         seen_age;
		logic [3:0]         data_age;
		logic signed [15:0] reading;
	} entry_t;

	// One result item.
	typedef struct packed {
		status_t            status;
		logic [63:0]        id;
		logic signed [15:0] reading;
	} result_t;

	localparam entry_t ResetEntry = '{
		id: 64'd0, seen_age: 4'd0, data_age: LimitAtReset, reading: 16'sd0
	};

	localparam result_t ZeroResult = '{
		status: STS_OK, id: 64'd0, reading: 16'sd0
	};

	// Answer for a zero id or a slot outside the table.
	localparam result_t EmptyResult = '{
		status: STS_EMPTY, id: 64'd0, reading: 16'sd0
	};

	// Answer for a lookup of an id that is not in the table.
	localparam result_t NotFoundResult = '{
		status: STS_NOTFOUND, id: 64'd0, reading: 16'sd0
	};

	// Result of reading one slot: empty, stale or ok.
	function automatic result_t read_result(entry_t e, logic [3:0] data_limit);
		result_t r;
		r = ZeroResult;
		if (e.id == 64'd0) begin
			r.status = STS_EMPTY;
		end else if (e.data_age >= data_limit) begin
			r.status = STS_STALE;
			r.id     = e.id;
		end else begin
			r.status  = STS_OK;
			r.id      = e.id;
			r.reading = e.reading;
		end
		return r;
	endfunction

endpackage

// ----- design/adit_req_if.sv -----
// Request channel of the aged device id table: valid, ready and one command.
// Depends on nothing.
interface adit_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic [63:0]        device_id;
	logic [2:0]         slot;
	logic signed [15:0] reading;

	modport source (output valid, command, device_id, slot, reading, input ready);
	modport sink (input valid, command, device_id, slot, reading, output ready);
endinterface

// ----- design/adit_rsp_if.sv -----
// Result channel of the aged device id table: valid, ready and one result.
// Depends on nothing.
interface adit_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [63:0]        id_out;
	logic signed [15:0] reading_out;

	modport source (output valid, status, id_out, reading_out, input ready);
	modport sink (input valid, status, id_out, reading_out, output ready);
endinterface

// ----- design/adit_cfg_if.sv -----
// Configuration write channel of the aged device id table.
// Depends on adit_pkg for the index width.
interface adit_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [adit_pkg::CfgIdxW-1:0] index;
	logic [3:0]                  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/aged_device_id_table.sv -----
// Top level of the aged device id table. Uses adit_pkg and the three
// channel interfaces adit_req_if, adit_rsp_if and adit_cfg_if.
//
// A table of SLOTS entries, each holding a device id, a signed reading and
// a seen age and data age, kept in one single-port-read, single-port-write
// memory. One request is handled at a time. seen_id, end_scan and read_by_id
// walk every slot through the one memory read port and a single compare and
// age-update unit, one slot per cycle. seen_id then rewrites the chosen
// slot; store_data and read_by_slot touch at most one slot; the other
// cases, a zero id included, touch no slot. A result that is not taken
// holds the next one in the sequencer for as long as it waits. The
// request side is ready again as soon as the result sits in the output
// register, even while that result waits to be taken. Per-slot valid bits
// give the reset contents at once, so there is no clearing pass after
// reset. Configuration writes are always taken and belong in idle periods.
module aged_device_id_table #(
	parameter int SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	adit_req_if.sink   req,
	adit_rsp_if.source rsp,
	adit_cfg_if.sink   cfg
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LastSlot = IW'(SLOTS - 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WALK   = 6'b000010,
		ST_PICK   = 6'b000100,
		ST_ISSUE  = 6'b001000,
		ST_MODIFY = 6'b010000,
		ST_RESP   = 6'b100000
	} state_t;

	state_t              state_q;
	logic [2:0]          cmd_q;
	logic [63:0]         id_q;
	logic [IW-1:0]       tgt_q;
	logic signed [15:0]  rdg_q;
	logic [3:0]          seen_lim_q;
	logic [3:0]          data_lim_q;
	logic [IW-1:0]       cnt_q;
	logic                issued_all_q;
	logic                live_s1;
	logic [IW-1:0]       idx_s1;
	logic                rvld_s1;
	adit_pkg::entry_t    rdat_s1;
	logic [SLOTS-1:0]    valid_q;
	logic                found_q;
	logic [IW-1:0]       found_idx_q;
	logic                empty_q;
	logic [IW-1:0]       empty_idx_q;
	logic [IW-1:0]       max_idx_q;
	logic [3:0]          max_age_q;
	adit_pkg::result_t   res_q;
	adit_pkg::result_t   rsp_q;
	logic                rsp_valid_q;
	adit_pkg::entry_t    mem_q [SLOTS];

	adit_pkg::entry_t    entry_s1;
	adit_pkg::entry_t    aged;
	adit_pkg::entry_t    wr_data;
	adit_pkg::result_t   slot_res;
	logic [IW-1:0]       rd_addr;
	logic [IW-1:0]       wr_addr;
	logic                wr_en;
	logic                hit;
	logic                walk_end;
	logic                req_fire;
	logic                slot_ok;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && (state_q == ST_IDLE);
	assign slot_ok   = 32'(req.slot) < SLOTS;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.id_out      = rsp_q.id;
	assign rsp.reading_out = rsp_q.reading;

	// A slot never written since reset reads as the reset entry.
	assign entry_s1 = rvld_s1 ? rdat_s1 : adit_pkg::ResetEntry;
	assign slot_res = adit_pkg::read_result(entry_s1, data_lim_q);
	assign hit      = (entry_s1.id == id_q);
	assign walk_end = (state_q == ST_WALK) && live_s1 && (idx_s1 == LastSlot);
	assign rd_addr  = (state_q == ST_WALK) ? cnt_q : tgt_q;

	// Shared age-update unit used by the end-of-scan walk.
	always_comb begin
		aged = entry_s1;
		if (entry_s1.id != 64'd0) begin
			if (entry_s1.seen_age < seen_lim_q) begin
				aged.seen_age = entry_s1.seen_age + 4'd1;
			end else begin
				aged.id = 64'd0;
			end
			if (entry_s1.data_age < data_lim_q) begin
				aged.data_age = entry_s1.data_age + 4'd1;
			end
		end
	end

	// Memory write selection: write-back during the scan walk, or the
	// read-modify-write of one slot.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tgt_q;
		wr_data = entry_s1;
		if ((state_q == ST_WALK) && live_s1 && (cmd_q == adit_pkg::CMD_END)) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1;
			wr_data = aged;
		end else if (state_q == ST_MODIFY) begin
			if (cmd_q == adit_pkg::CMD_SEEN) begin
				wr_en = 1'b1;
				wr_data.seen_age = 4'd0;
				if (!found_q) begin
					wr_data.id       = id_q;
					wr_data.data_age = data_lim_q;
				end
			end else if (cmd_q == adit_pkg::CMD_STORE) begin
				wr_en = 1'b1;
				wr_data.reading  = rdg_q;
				wr_data.data_age = 4'd0;
			end
		end
	end

	// Slot memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdat_s1 <= mem_q[rd_addr];
	end

	// Request payload latch.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= req.command;
			id_q  <= req.device_id;
			rdg_q <= req.reading;
		end
	end

	// Sequencer, walk bookkeeping, valid bits, limits and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seen_lim_q   <= adit_pkg::LimitAtReset;
			data_lim_q   <= adit_pkg::LimitAtReset;
			valid_q      <= '0;
			rvld_s1      <= 1'b0;
			live_s1      <= 1'b0;
			idx_s1       <= '0;
			cnt_q        <= '0;
			issued_all_q <= 1'b0;
			tgt_q        <= '0;
			found_q      <= 1'b0;
			found_idx_q  <= '0;
			empty_q      <= 1'b0;
			empty_idx_q  <= '0;
			max_idx_q    <= '0;
			max_age_q    <= '0;
			res_q        <= adit_pkg::ZeroResult;
			rsp_q        <= adit_pkg::ZeroResult;
			rsp_valid_q  <= 1'b0;
		end else begin
			// Configuration writes.
			if (cfg.valid) begin
				if (cfg.index == adit_pkg::CFG_SEEN_LIMIT) begin
					seen_lim_q <= cfg.data;
				end else if (cfg.index == adit_pkg::CFG_DATA_LIMIT) begin
					data_lim_q <= cfg.data;
				end
			end

			// Read pipeline bookkeeping.
			rvld_s1 <= valid_q[rd_addr];
			live_s1 <= (state_q == ST_WALK) && !issued_all_q;
			idx_s1  <= cnt_q;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end

			// The output register empties when its result is taken and no
			// new result replaces it.
			if (rsp_valid_q && rsp.ready && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						tgt_q        <= IW'(req.slot);
						cnt_q        <= '0;
						issued_all_q <= 1'b0;
						found_q      <= 1'b0;
						empty_q      <= 1'b0;
						case (req.command)
							adit_pkg::CMD_SEEN, adit_pkg::CMD_RID: begin
								if (req.device_id == 64'd0) begin
									res_q   <= adit_pkg::EmptyResult;
									state_q <= ST_RESP;
								end else begin
									res_q   <= adit_pkg::ZeroResult;
									state_q <= ST_WALK;
								end
							end
							adit_pkg::CMD_END: begin
								res_q   <= adit_pkg::ZeroResult;
								state_q <= ST_WALK;
							end
							adit_pkg::CMD_STORE: begin
								res_q   <= adit_pkg::ZeroResult;
								state_q <= slot_ok ? ST_ISSUE : ST_RESP;
							end
							adit_pkg::CMD_RSLOT: begin
								res_q   <= slot_ok ? adit_pkg::ZeroResult
									: adit_pkg::EmptyResult;
								state_q <= slot_ok ? ST_ISSUE : ST_RESP;
							end
							default: begin
								res_q   <= adit_pkg::ZeroResult;
								state_q <= ST_RESP;
							end
						endcase
					end
				end

				ST_WALK: begin
					// Issue one slot read per cycle.
					if (!issued_all_q) begin
						if (cnt_q == LastSlot) begin
							issued_all_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					// Examine the slot read in the previous cycle.
					if (live_s1) begin
						if (hit && !found_q) begin
							found_q     <= 1'b1;
							found_idx_q <= idx_s1;
						end
						if ((entry_s1.id == 64'd0) && !empty_q) begin
							empty_q     <= 1'b1;
							empty_idx_q <= idx_s1;
						end
						if ((idx_s1 == '0) || (entry_s1.seen_age > max_age_q)) begin
							max_idx_q <= idx_s1;
							max_age_q <= entry_s1.seen_age;
						end
					end
					// The first hit gives the lookup answer; a scan answers zero
					// and a lookup that ends without a hit answers not found.
					if (walk_end && (cmd_q == adit_pkg::CMD_END)) begin
						res_q <= adit_pkg::ZeroResult;
					end else if (walk_end && (cmd_q == adit_pkg::CMD_RID) && !found_q
							&& !hit) begin
						res_q <= adit_pkg::NotFoundResult;
					end else if (live_s1 && hit && !found_q) begin
						res_q <= slot_res;
					end
					if (walk_end) begin
						state_q <= (cmd_q == adit_pkg::CMD_SEEN) ? ST_PICK : ST_RESP;
					end
				end

				ST_PICK: begin
					// Known slot first, then the first empty one, else the oldest.
					res_q <= adit_pkg::ZeroResult;
					if (found_q) begin
						tgt_q <= found_idx_q;
					end else if (empty_q) begin
						tgt_q <= empty_idx_q;
					end else begin
						tgt_q <= max_idx_q;
					end
					state_q <= ST_ISSUE;
				end

				ST_ISSUE: begin
					state_q <= ST_MODIFY;
				end

				ST_MODIFY: begin
					if (cmd_q == adit_pkg::CMD_RSLOT) begin
						res_q <= slot_res;
					end
					state_q <= ST_RESP;
				end

				ST_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
